@@ sv/kpm_pkg.sv @@
// shared constants, codes and controller/datapath handshake types for the
// k-mer position multimap; no dependencies
package kpm_pkg;

   localparam int BUCKETS_DEF       = 1024;
   localparam int MAX_KEYS_DEF      = 4096;
   localparam int MAX_POSITIONS_DEF = 16384;
   localparam int MAX_PER_KEY_DEF   = 255;

   localparam int KEY_W  = 64;
   localparam int POS_W  = 32;
   localparam int IDX_W  = 8;
   localparam int CNT_W  = 8;
   localparam int STAT_W = 2;

   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_LIST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_STORE_FULL = 2'd2;

   localparam logic [63:0] MIX_C1 = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_C2 = 64'hBF58476D1CE4E5B9;

   typedef struct packed {
      logic latch_req;
      logic hash_start;
      logic clr_wr;
      logic bkt_rd;
      logic head_load;
      logic key_rd;
      logic key_next;
      logic hit_load;
      logic commit;
      logic pos_start;
      logic pos_rd;
      logic pos_next;
      logic pos_take;
      logic load_out;
   } kpm_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_done;
      logic e_null;
      logic key_match;
      logic is_get;
      logic get_walk;
      logic k_hit;
   } kpm_stat_type;

endpackage

@@ sv/kpm_if.sv @@
// request and response channel interfaces of the k-mer position multimap
// depends on kpm_pkg
interface kpm_req_if import kpm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [KEY_W-1:0] kmer_key;
   logic [POS_W-1:0] position_in;
   logic [IDX_W-1:0] list_index;

   modport source (output valid, func, kmer_key, position_in, list_index, input ready);
   modport sink   (input valid, func, kmer_key, position_in, list_index, output ready);
endinterface

interface kpm_rsp_if import kpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic [CNT_W-1:0]  count;
   logic [POS_W-1:0]  position_out;
   logic [STAT_W-1:0] status;

   modport source (output valid, found, count, position_out, status, input ready);
   modport sink   (input valid, found, count, position_out, status, output ready);
endinterface

@@ sv/kmer_position_multimap.sv @@
// k-mer position multimap: 64-bit key -> newest-first list of 32-bit positions
// throughput: one item at a time; a stalled result holds the next
// reset: synchronous; a clearing pass empties the bucket table, no item taken
module kmer_position_multimap import kpm_pkg::*; #(
   parameter int BUCKETS       = BUCKETS_DEF,
   parameter int MAX_KEYS      = MAX_KEYS_DEF,
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int MAX_PER_KEY   = MAX_PER_KEY_DEF
) (
   input  logic clock,
   input  logic reset,
   kpm_req_if.sink   req,
   kpm_rsp_if.source rsp
);

   kpm_cmd_type  cmd;
   kpm_stat_type stat;

   kpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   kpm_datapath #(
      .BUCKETS       (BUCKETS),
      .MAX_KEYS      (MAX_KEYS),
      .MAX_POSITIONS (MAX_POSITIONS),
      .MAX_PER_KEY   (MAX_PER_KEY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req.func),
      .req_kmer_key     (req.kmer_key),
      .req_position_in  (req.position_in),
      .req_list_index   (req.list_index),
      .rsp_found        (rsp.found),
      .rsp_count        (rsp.count),
      .rsp_position_out (rsp.position_out),
      .rsp_status       (rsp.status)
   );

endmodule

@@ sv/kpm_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no dependencies
module kpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/kpm_hash.sv @@
// multi-cycle bucket hash: two 64-bit multiply/xor-shift rounds on one shared
// 32x32 multiplier, then remainder by BUCKETS; depends on kpm_pkg
module kpm_hash import kpm_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF,
   localparam int BAW = $clog2(BUCKETS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [BAW-1:0]   bucket
);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_M1   = 3'd1;
   localparam logic [2:0] P_X1   = 3'd2;
   localparam logic [2:0] P_M2   = 3'd3;
   localparam logic [2:0] P_X2   = 3'd4;
   localparam logic [2:0] P_MOD  = 3'd5;
   localparam logic [2:0] P_DONE = 3'd6;

   localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam logic [BAW:0] BKT_C = (BAW+1)'(BUCKETS);

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [BAW-1:0] rem_ff, rem_in;

   logic [63:0] mul_c;
   logic [31:0] op_a, op_b;
   logic [BAW:0] rem_ext;

   always_comb begin
      mul_c = (phase_ff == P_M1) ? MIX_C1 : MIX_C2;
      case (cnt_ff[1:0])
         2'd0:    begin op_a = val_ff[31:0];  op_b = mul_c[31:0];  end
         2'd1:    begin op_a = val_ff[31:0];  op_b = mul_c[63:32]; end
         default: begin op_a = val_ff[63:32]; op_b = mul_c[31:0];  end
      endcase
      prod_in = {32'd0, op_a} * {32'd0, op_b};
      // four restoring steps per cycle, msb first
      rem_ext = {1'b0, rem_ff};
      for (int i = 0; i < 4; i++) begin
         rem_ext = {rem_ext[BAW-1:0], val_ff[6'd63 - {cnt_ff[3:0], 2'(i)}]};
         if (rem_ext >= BKT_C) begin
            rem_ext = rem_ext - BKT_C;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      if (start) begin
         phase_in = P_M1;
         cnt_in   = '0;
         val_in   = key;
      end else begin
         unique case (phase_ff)
            P_M1, P_M2: begin
               // low 64 bits of the product from three partial products
               if (cnt_ff == 6'd1) begin
                  acc_in = prod_ff;
               end else if (cnt_ff != 6'd0) begin
                  acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               end
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd3) begin
                  phase_in = (phase_ff == P_M1) ? P_X1 : P_X2;
               end
            end
            P_X1: begin
               val_in   = acc_ff ^ (acc_ff >> 29);
               cnt_in   = '0;
               phase_in = P_M2;
            end
            P_X2: begin
               val_in   = acc_ff ^ (acc_ff >> 32);
               cnt_in   = '0;
               rem_in   = '0;
               phase_in = P_MOD;
            end
            P_MOD: begin
               if (POW2) begin
                  phase_in = P_DONE;
               end else begin
                  // restoring remainder, four hashed-value bits per cycle
                  rem_in = rem_ext[BAW-1:0];
                  cnt_in = cnt_ff + 6'd1;
                  if (cnt_ff == 6'd15) begin
                     phase_in = P_DONE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      val_ff  <= val_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = (phase_ff == P_DONE);
   assign bucket = POW2 ? val_ff[BAW-1:0] : rem_ff;

endmodule

@@ sv/kpm_datapath.sv @@
// datapath: request latch, hash unit, bucket/key/position memories, chain
// pointers and result registers; depends on kpm_pkg, kpm_hash, kpm_ram
module kpm_datapath import kpm_pkg::*; #(
   parameter int BUCKETS       = BUCKETS_DEF,
   parameter int MAX_KEYS      = MAX_KEYS_DEF,
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int MAX_PER_KEY   = MAX_PER_KEY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  kpm_cmd_type       cmd,
   output kpm_stat_type      stat,
   input  logic              req_func,
   input  logic [KEY_W-1:0]  req_kmer_key,
   input  logic [POS_W-1:0]  req_position_in,
   input  logic [IDX_W-1:0]  req_list_index,
   output logic              rsp_found,
   output logic [CNT_W-1:0]  rsp_count,
   output logic [POS_W-1:0]  rsp_position_out,
   output logic [STAT_W-1:0] rsp_status
);

   localparam int BAW = $clog2(BUCKETS);
   localparam int KAW = $clog2(MAX_KEYS);
   localparam int KW  = $clog2(MAX_KEYS + 1);
   localparam int PAW = $clog2(MAX_POSITIONS);
   localparam int PW  = $clog2(MAX_POSITIONS + 1);
   localparam int KWORD = KEY_W + KW + CNT_W + PW;
   localparam int PWORD = POS_W + PW;
   localparam logic [KW-1:0] NULL_K = KW'(MAX_KEYS);
   localparam logic [PW-1:0] NULL_P = PW'(MAX_POSITIONS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PER_KEY);

   logic             func_ff;
   logic [KEY_W-1:0] key_ff;
   logic [POS_W-1:0] posin_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [KW-1:0]    head_ff, head_in;
   logic [KW-1:0]    e_ff, e_in;
   logic [KW-1:0]    enext_ff, enext_in;
   logic [PW-1:0]    first_ff, first_in;
   logic             present_ff, present_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pout_ff, pout_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [KW-1:0]    ku_ff, ku_in;
   logic [PW-1:0]    pu_ff, pu_in;
   logic [BAW-1:0]   clr_ff;
   logic             o_found_ff;
   logic [CNT_W-1:0] o_count_ff;
   logic [POS_W-1:0] o_pos_ff;
   logic [STAT_W-1:0] o_status_ff;

   logic           hash_done;
   logic [BAW-1:0] bucket;

   logic             bkt_we;
   logic [BAW-1:0]   bkt_wa;
   logic [KW-1:0]    bkt_wd, bkt_rd;
   logic             key_we;
   logic [KAW-1:0]   key_wa;
   logic [KWORD-1:0] key_wd, key_rd;
   logic             pos_we;
   logic [PAW-1:0]   pos_wa;
   logic [PWORD-1:0] pos_wd, pos_rd;

   logic [KEY_W-1:0] rd_key;
   logic [KW-1:0]    rd_enext;
   logic [CNT_W-1:0] rd_count;
   logic [PW-1:0]    rd_first;
   logic [POS_W-1:0] rd_pval;
   logic [PW-1:0]    rd_pnext;
   logic             pos_full, keys_full;

   kpm_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.hash_start),
      .key    (key_ff),
      .done   (hash_done),
      .bucket (bucket)
   );

   kpm_ram #(.WIDTH(KW), .DEPTH(BUCKETS)) u_bkt_ram (
      .clock (clock), .wr_en (bkt_we), .wr_addr (bkt_wa), .wr_data (bkt_wd),
      .rd_en (cmd.bkt_rd), .rd_addr (bucket), .rd_data (bkt_rd)
   );

   kpm_ram #(.WIDTH(KWORD), .DEPTH(MAX_KEYS)) u_key_ram (
      .clock (clock), .wr_en (key_we), .wr_addr (key_wa), .wr_data (key_wd),
      .rd_en (cmd.key_rd), .rd_addr (e_ff[KAW-1:0]), .rd_data (key_rd)
   );

   kpm_ram #(.WIDTH(PWORD), .DEPTH(MAX_POSITIONS)) u_pos_ram (
      .clock (clock), .wr_en (pos_we), .wr_addr (pos_wa), .wr_data (pos_wd),
      .rd_en (cmd.pos_rd), .rd_addr (p_ff[PAW-1:0]), .rd_data (pos_rd)
   );

   assign {rd_key, rd_enext, rd_count, rd_first} = key_rd;
   assign {rd_pval, rd_pnext} = pos_rd;
   assign pos_full  = (pu_ff >= NULL_P);
   assign keys_full = (ku_ff >= NULL_K);

   always_comb begin
      head_in    = head_ff;
      e_in       = e_ff;
      enext_in   = enext_ff;
      first_in   = first_ff;
      present_in = present_ff;
      count_in   = count_ff;
      pout_in    = pout_ff;
      status_in  = status_ff;
      p_in       = p_ff;
      k_in       = k_ff;
      ku_in      = ku_ff;
      pu_in      = pu_ff;
      bkt_we = 1'b0;
      bkt_wa = clr_ff;
      bkt_wd = NULL_K;
      key_we = 1'b0;
      key_wa = e_ff[KAW-1:0];
      key_wd = '0;
      pos_we = 1'b0;
      pos_wa = pu_ff[PAW-1:0];
      pos_wd = '0;

      if (cmd.clr_wr) begin
         bkt_we = 1'b1;
      end
      if (cmd.latch_req) begin
         present_in = 1'b0;
         count_in   = '0;
         pout_in    = '0;
         status_in  = ST_OK;
      end
      if (cmd.head_load) begin
         head_in = bkt_rd;
         e_in    = bkt_rd;
      end
      if (cmd.key_next) begin
         e_in = rd_enext;
      end
      if (cmd.hit_load) begin
         present_in = 1'b1;
         count_in   = rd_count;
         first_in   = rd_first;
         enext_in   = rd_enext;
      end
      if (cmd.commit) begin
         if (present_ff) begin
            if (count_ff >= CNT_MAX) begin
               status_in = ST_LIST_FULL;
            end else if (pos_full) begin
               status_in = ST_STORE_FULL;
            end else begin
               pos_we   = 1'b1;
               pos_wd   = {posin_ff, first_ff};
               key_we   = 1'b1;
               key_wd   = {key_ff, enext_ff, count_ff + CNT_W'(1), pu_ff};
               pu_in    = pu_ff + PW'(1);
               count_in = count_ff + CNT_W'(1);
            end
         end else if (keys_full || pos_full) begin
            status_in = ST_STORE_FULL;
         end else begin
            // new key goes to the front of its bucket chain
            pos_we   = 1'b1;
            pos_wd   = {posin_ff, NULL_P};
            key_we   = 1'b1;
            key_wa   = ku_ff[KAW-1:0];
            key_wd   = {key_ff, head_ff, CNT_W'(1), pu_ff};
            bkt_we   = 1'b1;
            bkt_wa   = bucket;
            bkt_wd   = ku_ff;
            ku_in    = ku_ff + KW'(1);
            pu_in    = pu_ff + PW'(1);
            count_in = CNT_W'(1);
         end
      end
      if (cmd.pos_start) begin
         p_in = first_ff;
         k_in = '0;
      end
      if (cmd.pos_next) begin
         p_in = rd_pnext;
         k_in = k_ff + IDX_W'(1);
      end
      if (cmd.pos_take) begin
         pout_in = rd_pval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ku_ff  <= '0;
         pu_ff  <= '0;
         clr_ff <= '0;
      end else begin
         ku_ff <= ku_in;
         pu_ff <= pu_in;
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + BAW'(1);
         end
      end
      if (cmd.latch_req) begin
         func_ff  <= req_func;
         key_ff   <= req_kmer_key;
         posin_ff <= req_position_in;
         idx_ff   <= req_list_index;
      end
      head_ff    <= head_in;
      e_ff       <= e_in;
      enext_ff   <= enext_in;
      first_ff   <= first_in;
      present_ff <= present_in;
      count_ff   <= count_in;
      pout_ff    <= pout_in;
      status_ff  <= status_in;
      p_ff       <= p_in;
      k_ff       <= k_in;
      if (cmd.load_out) begin
         o_found_ff  <= present_ff;
         o_count_ff  <= count_ff;
         o_pos_ff    <= pout_ff;
         o_status_ff <= status_ff;
      end
   end

   assign stat.clr_last  = (clr_ff == BAW'(BUCKETS - 1));
   assign stat.hash_done = hash_done;
   assign stat.e_null    = (e_ff >= NULL_K);
   assign stat.key_match = (rd_key == key_ff);
   assign stat.is_get    = (func_ff == FUNC_GET);
   assign stat.get_walk  = (func_ff == FUNC_GET) && present_ff && (idx_ff < count_ff);
   assign stat.k_hit     = (k_ff == idx_ff);

   assign rsp_found        = o_found_ff;
   assign rsp_count        = o_count_ff;
   assign rsp_position_out = o_pos_ff;
   assign rsp_status       = o_status_ff;

   a_ku_bound: assert property (@(posedge clock) disable iff (reset) ku_ff <= NULL_K)
      else $error("key allocation ran past the key store");
   a_pu_bound: assert property (@(posedge clock) disable iff (reset) pu_ff <= NULL_P)
      else $error("position allocation ran past the position store");
   a_one_alloc: assert property (@(posedge clock) disable iff (reset)
      (ku_ff != $past(ku_ff)) |-> (pu_ff != $past(pu_ff)))
      else $error("new key allocated without a position node");
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_rd |-> (p_ff < NULL_P))
      else $error("position chain walk left the store");

endmodule

@@ sv/kpm_ctrl.sv @@
// controller: sequences bucket clear, hash, key-chain walk, put commit,
// position-chain walk and the response register; depends on kpm_pkg
module kpm_ctrl import kpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output kpm_cmd_type  cmd,
   input  kpm_stat_type stat
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HSTART = 4'd2;
   localparam logic [3:0] S_HASH   = 4'd3;
   localparam logic [3:0] S_BKT    = 4'd4;
   localparam logic [3:0] S_WALK   = 4'd5;
   localparam logic [3:0] S_KEY    = 4'd6;
   localparam logic [3:0] S_DECIDE = 4'd7;
   localparam logic [3:0] S_PRD    = 4'd8;
   localparam logic [3:0] S_PWAIT  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = S_HSTART;
            end
         end
         S_HSTART: begin
            cmd.hash_start = 1'b1;
            state_in = S_HASH;
         end
         S_HASH: begin
            if (stat.hash_done) begin
               cmd.bkt_rd = 1'b1;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            cmd.head_load = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (stat.e_null) begin
               state_in = S_DECIDE;
            end else begin
               cmd.key_rd = 1'b1;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if (stat.key_match) begin
               cmd.hit_load = 1'b1;
               state_in = S_DECIDE;
            end else begin
               cmd.key_next = 1'b1;
               state_in = S_WALK;
            end
         end
         S_DECIDE: begin
            if (!stat.is_get) begin
               cmd.commit = 1'b1;
               state_in = S_DONE;
            end else if (stat.get_walk) begin
               cmd.pos_start = 1'b1;
               state_in = S_PRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PRD: begin
            cmd.pos_rd = 1'b1;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (stat.k_hit) begin
               cmd.pos_take = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.pos_next = 1'b1;
               state_in = S_PRD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result register overwritten before transfer");
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_HSTART))
      else $error("accepted request not started");
   a_commit_put: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.is_get)
      else $error("store update issued for a get");

endmodule
